// File: design/bvs_pkg.sv
// bvs_pkg: shared types, constants and the channel scaling table for the
// bitplane video shifter. No dependencies.
package bvs_pkg;

  localparam int MEMORY_BYTES = 4194304;
  localparam int LINE_BYTES   = 160;
  localparam int VISIBLE_ROWS = 240;

  // highest line address whose full line still fits in memory
  localparam logic [23:0] ADDR_LIMIT = 24'(MEMORY_BYTES - LINE_BYTES);

  // configuration register indexes
  localparam logic CFG_RES_MODE   = 1'b0;
  localparam logic CFG_ROW_OFFSET = 1'b1;

  localparam logic [4:0] ROW_OFFSET_RST = 5'd20;

  // input kinds (tuser)
  localparam logic ACT_PALETTE = 1'b0;
  localparam logic ACT_DRAW    = 1'b1;

  typedef logic [11:0] color_t;

  // per-pixel position info from the serializer
  typedef struct packed {
    logic [9:0] x;
    logic [7:0] y;
    logic       last;
  } pix_ctl_t;

  // 3-bit channel to 8 bits, floor(36.428 * c)
  function automatic logic [7:0] chan_scale(input logic [2:0] c);
    logic [7:0] v;
    case (c)
      3'd0:    v = 8'd0;
      3'd1:    v = 8'd36;
      3'd2:    v = 8'd72;
      3'd3:    v = 8'd109;
      3'd4:    v = 8'd145;
      3'd5:    v = 8'd182;
      3'd6:    v = 8'd218;
      default: v = 8'd254;
    endcase
    return v;
  endfunction

endpackage

// File: design/bitplane_video_shifter.sv
// bitplane_video_shifter: top level. Input checks, configuration registers,
// output register. Uses bvs_pkg, bvs_palette and bvs_serializer.
//
// Usage:
//   in_*  : one word per item. tuser = 0 writes a palette entry, tuser = 1
//           draws one 16-pixel group from four (or two) plane words.
//   out_* : one word per pixel, leftmost first; tlast marks the 16th pixel.
//   cfg_* : register writes (0 resolution mode, 1 row offset), always ready.
//           Write only while no group is in flight.
// Flow: a taken draw word loads the pixel serializer, and each pixel then moves
// to the output register. A visible group occupies the serializer for its 16
// pixels, one palette lookup per cycle while the output is not stalled; the next
// word is taken in the cycle the 16th pixel moves to the output register.
// Palette writes and groups that fall outside the visible rows or the memory
// produce nothing.
// Reset (synchronous, rst_n low) clears the palette to zero, sets low
// resolution and a row offset of 20, and drops all pending pixels.
// When out_tready is low the output register holds its pixel and the
// serializer and input side stall behind it.
module bitplane_video_shifter (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // palette_index[3:0], palette_color[15:4], screen_row[24:16],
  // line_address[48:25], group_column[54:49], plane0_word[70:55],
  // plane1_word[86:71], plane2_word[102:87], plane3_word[118:103], pad[119]
  input  logic [119:0] in_tdata,
  // action[0]
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // pixel_x[9:0], pixel_y[17:10], red[25:18], green[33:26], blue[41:34],
  // pad[47:42]
  output logic [47:0]  out_tdata,
  output logic         out_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic         cfg_index,
  input  logic [4:0]   cfg_data
);

  logic [3:0]  in_pal_idx;
  logic [11:0] in_color;
  logic [8:0]  in_row;
  logic [23:0] in_addr;
  logic [5:0]  in_col;
  logic [15:0] in_p0, in_p1, in_p2, in_p3;

  assign in_pal_idx = in_tdata[3:0];
  assign in_color   = in_tdata[15:4];
  assign in_row     = in_tdata[24:16];
  assign in_addr    = in_tdata[48:25];
  assign in_col     = in_tdata[54:49];
  assign in_p0      = in_tdata[70:55];
  assign in_p1      = in_tdata[86:71];
  assign in_p2      = in_tdata[102:87];
  assign in_p3      = in_tdata[118:103];

  // configuration
  logic       res_mode_r;
  logic [4:0] row_off_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_mode_r <= 1'b0;
      row_off_r  <= bvs_pkg::ROW_OFFSET_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bvs_pkg::CFG_RES_MODE:   res_mode_r <= cfg_data[0];
        bvs_pkg::CFG_ROW_OFFSET: row_off_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // visibility checks
  logic [9:0] shown_row;
  logic       row_ok, addr_ok;

  assign shown_row = {in_row[8], in_row} + {5'b0, row_off_r};
  assign row_ok    = !shown_row[9] && (shown_row[8:0] < 9'(bvs_pkg::VISIBLE_ROWS));
  assign addr_ok   = (in_addr <= bvs_pkg::ADDR_LIMIT);

  // handshake
  logic              busy;
  logic              advance;
  logic              take;
  logic              out_valid_r;
  logic [3:0]        pal_idx;
  bvs_pkg::pix_ctl_t ctl;
  logic [7:0]        red, green, blue;

  assign advance   = busy && (!out_valid_r || out_tready);
  assign in_tready = !busy || (advance && ctl.last);
  assign take      = in_tvalid && in_tready;

  bvs_palette u_palette (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (take && (in_tuser == bvs_pkg::ACT_PALETTE)),
    .wr_idx   (in_pal_idx),
    .wr_color (in_color),
    .rd_idx   (pal_idx),
    .red      (red),
    .green    (green),
    .blue     (blue)
  );

  bvs_serializer u_serializer (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (take && (in_tuser == bvs_pkg::ACT_DRAW) && row_ok && addr_ok),
    .advance  (advance),
    .res_mode (res_mode_r),
    .column   (in_col),
    .row      (shown_row[7:0]),
    .plane0   (in_p0),
    .plane1   (in_p1),
    .plane2   (in_p2),
    .plane3   (in_p3),
    .busy     (busy),
    .pal_idx  (pal_idx),
    .ctl      (ctl)
  );

  // output register
  logic [47:0] out_data_r;
  logic        out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= {6'b0, blue, green, red, ctl.y, ctl.x};
      out_last_r <= ctl.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// File: design/bvs_palette.sv
// bvs_palette: 16-entry color palette with one write port and one read port,
// returning the read entry scaled to 8 bits per channel. Uses bvs_pkg.
module bvs_palette (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [3:0]          wr_idx,
  input  bvs_pkg::color_t     wr_color,
  input  logic [3:0]          rd_idx,
  output logic [7:0]          red,
  output logic [7:0]          green,
  output logic [7:0]          blue
);

  bvs_pkg::color_t pal_r [16];
  bvs_pkg::color_t rd_color;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        pal_r[i] <= '0;
      end
    end else if (wr_en) begin
      pal_r[wr_idx] <= wr_color;
    end
  end

  assign rd_color = pal_r[rd_idx];
  assign red   = bvs_pkg::chan_scale(rd_color[10:8]);
  assign green = bvs_pkg::chan_scale(rd_color[6:4]);
  assign blue  = bvs_pkg::chan_scale(rd_color[2:0]);

endmodule

// File: design/bvs_serializer.sv
// bvs_serializer: holds one group's plane words and steps through its 16
// pixels, MSB first, giving the palette index and pixel position. Uses bvs_pkg.
module bvs_serializer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  logic                advance,
  input  logic                res_mode,
  input  logic [5:0]          column,
  input  logic [7:0]          row,
  input  logic [15:0]         plane0,
  input  logic [15:0]         plane1,
  input  logic [15:0]         plane2,
  input  logic [15:0]         plane3,
  output logic                busy,
  output logic [3:0]          pal_idx,
  output bvs_pkg::pix_ctl_t   ctl
);

  logic        busy_r, busy_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [5:0]  col_r;
  logic [7:0]  row_r;
  logic [15:0] p0_r, p1_r, p2_r, p3_r;
  logic        last;

  assign last = (cnt_r == 4'hf);

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (advance) begin
      cnt_nxt = cnt_r + 4'd1;
      if (last) begin
        busy_nxt = 1'b0;
      end
    end
    if (load) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // plane words shift left so bit 15 is always the current pixel
  always_ff @(posedge clk) begin
    if (load) begin
      col_r <= column;
      row_r <= row;
      p0_r  <= plane0;
      p1_r  <= plane1;
      p2_r  <= plane2;
      p3_r  <= plane3;
    end else if (advance) begin
      p0_r <= {p0_r[14:0], 1'b0};
      p1_r <= {p1_r[14:0], 1'b0};
      p2_r <= {p2_r[14:0], 1'b0};
      p3_r <= {p3_r[14:0], 1'b0};
    end
  end

  // medium resolution uses only planes 0 and 1
  assign pal_idx = {p3_r[15] & ~res_mode, p2_r[15] & ~res_mode, p1_r[15], p0_r[15]};

  assign busy     = busy_r;
  assign ctl.x    = {col_r, cnt_r};
  assign ctl.y    = row_r;
  assign ctl.last = last;

endmodule
